FILE: rtl/bmp_pkg.sv
package bmp_pkg;

	// Modulus and the width of every residue.
	localparam int unsigned MOD_W = 30;
	localparam logic [MOD_W-1:0] MOD_P = 30'd1000000007;

	// Fermat exponent for the inverse: P - 2.
	localparam logic [MOD_W-1:0] INV_EXP = MOD_P - 30'd2;
	localparam int unsigned EXP_BITS = MOD_W;
	localparam int unsigned BIT_W = 5;

	// Barrett constant floor(2^(2*MOD_W) / P), a 31-bit value.
	localparam int unsigned MU_W = MOD_W + 1;
	localparam logic [MU_W-1:0] BARRETT_MU =
		MU_W'((64'd1 << (2 * MOD_W)) / 64'd1000000007);

	// Width of the result channel's tdata (30-bit result padded to bytes).
	localparam int unsigned RES_TDATA_W = 32;

	// Operand selection and destination of one modular multiplication.
	typedef enum logic [2:0] {
		OP_FACT,
		OP_DEN,
		OP_ACC,
		OP_SQR,
		OP_FIN
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    init;
		logic    zero_res;
		logic    mul_go;
		mul_op_t go_op;
		logic    commit;
		mul_op_t commit_op;
	} bmp_cmd_t;

	typedef struct packed {
		logic k_gt_n;
		logic i_gt_n;
		logic mul_done;
	} bmp_status_t;

endpackage

FILE: rtl/bmp_mulmod.sv
module bmp_mulmod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [bmp_pkg::MOD_W-1:0] a,
	input  logic [bmp_pkg::MOD_W-1:0] b,
	output logic                     done,
	output logic [bmp_pkg::MOD_W-1:0] r
);
	import bmp_pkg::*;

	localparam int unsigned PROD_W = 2 * MOD_W;
	localparam int unsigned LO_W = MOD_W + 2;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic [PROD_W-1:0]    p_s1;
	logic [2*MU_W-1:0]    q_s2;
	logic [LO_W-1:0]      plo_s2, plo_s3;
	logic [LO_W-1:0]      qp_s3;
	logic [LO_W-1:0]      r_s4;
	logic [MOD_W-1:0]     r_s5;

	logic [MU_W+MOD_W-1:0] qp_full;
	logic [LO_W-1:0]       p1_lo, p2_lo;

	assign qp_full = q_s2[2*MU_W-1:MU_W] * MOD_P;
	assign p1_lo   = LO_W'(MOD_P);
	assign p2_lo   = LO_W'(MOD_P) << 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Barrett reduction: estimate the quotient, subtract q*P on the low bits,
	// then at most two corrections bring the remainder below P.
	always_ff @(posedge clk) begin
		p_s1   <= a * b;
		q_s2   <= p_s1[PROD_W-1:MOD_W-1] * BARRETT_MU;
		plo_s2 <= p_s1[LO_W-1:0];
		qp_s3  <= qp_full[LO_W-1:0];
		plo_s3 <= plo_s2;
		r_s4   <= plo_s3 - qp_s3;
		if (r_s4 >= p2_lo) begin
			r_s5 <= MOD_W'(r_s4 - p2_lo);
		end else if (r_s4 >= p1_lo) begin
			r_s5 <= MOD_W'(r_s4 - p1_lo);
		end else begin
			r_s5 <= MOD_W'(r_s4);
		end
	end

	assign done = vld_s5;
	assign r    = r_s5;

endmodule

FILE: rtl/bmp_datapath.sv
module bmp_datapath #(
	parameter int unsigned N_BITS = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [N_BITS-1:0]        n,
	input  logic [N_BITS-1:0]        k,
	input  bmp_pkg::bmp_cmd_t        cmd,
	output bmp_pkg::bmp_status_t     status,
	output logic [bmp_pkg::MOD_W-1:0] result
);
	import bmp_pkg::*;

	logic [N_BITS-1:0] n_q, k_q, nk_q;
	logic [N_BITS:0]   i_q;
	logic [MOD_W-1:0]  prod_q, fk_q, fnk_q, base_q, acc_q, result_q;
	logic [MOD_W-1:0]  op_a, op_b, mul_r;
	logic              mul_done;

	always_comb begin
		case (cmd.go_op)
			OP_FACT: begin
				op_a = prod_q;
				op_b = MOD_W'(i_q);
			end
			OP_DEN: begin
				op_a = fk_q;
				op_b = fnk_q;
			end
			OP_ACC: begin
				op_a = acc_q;
				op_b = base_q;
			end
			OP_SQR: begin
				op_a = base_q;
				op_b = base_q;
			end
			default: begin
				op_a = prod_q;
				op_b = acc_q;
			end
		endcase
	end

	bmp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mul_go),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.r      (mul_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n;
			k_q <= k;
		end
		if (cmd.init) begin
			nk_q   <= n_q - k_q;
			prod_q <= MOD_W'(1);
			fk_q   <= MOD_W'(1);
			fnk_q  <= MOD_W'(1);
			i_q    <= (N_BITS+1)'(1);
		end
		if (cmd.zero_res) begin
			result_q <= '0;
		end
		if (cmd.commit) begin
			case (cmd.commit_op)
				OP_FACT: begin
					prod_q <= mul_r;
					if (i_q == {1'b0, k_q}) begin
						fk_q <= mul_r;
					end
					if (i_q == {1'b0, nk_q}) begin
						fnk_q <= mul_r;
					end
					i_q <= i_q + 1'b1;
				end
				OP_DEN: begin
					base_q <= mul_r;
					acc_q  <= MOD_W'(1);
				end
				OP_ACC: begin
					acc_q <= mul_r;
				end
				OP_SQR: begin
					base_q <= mul_r;
				end
				OP_FIN: begin
					result_q <= mul_r;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.k_gt_n   = k_q > n_q;
	assign status.i_gt_n   = i_q > {1'b0, n_q};
	assign status.mul_done = mul_done;
	assign result          = result_q;

endmodule

FILE: rtl/bmp_ctrl.sv
module bmp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  bmp_pkg::bmp_status_t status,
	output bmp_pkg::bmp_cmd_t    cmd
);
	import bmp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ZERO,
		ST_FACT,
		ST_FACT_W,
		ST_DEN_W,
		ST_EXP,
		ST_ACC_W,
		ST_SQR_W,
		ST_FIN,
		ST_FIN_W
	} state_t;

	state_t           state_q, state_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic             out_valid_q;
	logic             out_free;
	logic             res_load;

	// The output register can take a new result once it is empty or being read.
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d       = state_q;
		bit_d         = bit_q;
		res_load      = 1'b0;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.go_op     = OP_FACT;
		cmd.commit_op = OP_FACT;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.k_gt_n) begin
					state_d = ST_ZERO;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_FACT;
				end
			end
			ST_ZERO: begin
				if (out_free) begin
					cmd.zero_res = 1'b1;
					res_load     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_FACT: begin
				cmd.mul_go = 1'b1;
				if (status.i_gt_n) begin
					cmd.go_op = OP_DEN;
					state_d   = ST_DEN_W;
				end else begin
					cmd.go_op = OP_FACT;
					state_d   = ST_FACT_W;
				end
			end
			ST_FACT_W: begin
				cmd.commit_op = OP_FACT;
				if (status.mul_done) begin
					cmd.commit = 1'b1;
					state_d    = ST_FACT;
				end
			end
			ST_DEN_W: begin
				cmd.commit_op = OP_DEN;
				if (status.mul_done) begin
					cmd.commit = 1'b1;
					bit_d      = '0;
					state_d    = ST_EXP;
				end
			end
			ST_EXP: begin
				cmd.mul_go = 1'b1;
				if (INV_EXP[bit_q]) begin
					cmd.go_op = OP_ACC;
					state_d   = ST_ACC_W;
				end else begin
					cmd.go_op = OP_SQR;
					state_d   = ST_SQR_W;
				end
			end
			ST_ACC_W: begin
				cmd.commit_op = OP_ACC;
				cmd.go_op     = OP_SQR;
				if (status.mul_done) begin
					cmd.commit = 1'b1;
					cmd.mul_go = 1'b1;
					state_d    = ST_SQR_W;
				end
			end
			ST_SQR_W: begin
				cmd.commit_op = OP_SQR;
				if (status.mul_done) begin
					cmd.commit = 1'b1;
					if (bit_q == BIT_W'(EXP_BITS - 1)) begin
						state_d = ST_FIN;
					end else begin
						bit_d   = bit_q + 1'b1;
						state_d = ST_EXP;
					end
				end
			end
			// The final product is started only once the output register is free,
			// so it can be written there the moment it comes out.
			ST_FIN: begin
				cmd.go_op = OP_FIN;
				if (out_free) begin
					cmd.mul_go = 1'b1;
					state_d    = ST_FIN_W;
				end
			end
			ST_FIN_W: begin
				cmd.commit_op = OP_FIN;
				if (status.mul_done) begin
					cmd.commit = 1'b1;
					res_load   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: rtl/binomial_mod_prime.sv
// Channel  Dir  Fields of tdata (lowest bit first)         Handshake
// s_*      in   n [N_BITS-1:0], k [2*N_BITS-1:N_BITS]       s_tvalid / s_tready
// m_*      out  result [29:0], zero padding above          m_tvalid / m_tready
//
// Every modular multiplication goes through one shared five-stage Barrett
// multiplier; the factorial walk takes n products, the denominator one and the
// inversion 45 (P-2 has 15 set bits, and each multiply is followed directly by
// its square). An item with k greater than n gets its zero result without any
// multiplication.
// Reset is asynchronous and active low; it clears the controller and the
// output valid flag. A stalled result sits in the output register while the
// next item is already taken and worked on; that item waits before its final
// product or its zero result until the register has been read.
module binomial_mod_prime #(
	parameter int unsigned N_BITS = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// n, then k, each N_BITS wide, zero padded to whole bytes.
	input  logic [((2*N_BITS+7)/8)*8-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// result (30 bits), then two zero bits.
	output logic [bmp_pkg::RES_TDATA_W-1:0]       m_tdata
);
	import bmp_pkg::*;

	bmp_cmd_t         cmd;
	bmp_status_t      status;
	logic [MOD_W-1:0] result;

	// The controller sequences the factorial walk, the Fermat inversion by
	// square-and-multiply over the bits of P-2 and the final product.
	bmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the operands, the captured factorials k! and (n-k)!,
	// the running product, the inversion accumulator and the result register.
	bmp_datapath #(
		.N_BITS (N_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.n      (s_tdata[N_BITS-1:0]),
		.k      (s_tdata[2*N_BITS-1:N_BITS]),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	assign m_tdata = RES_TDATA_W'(result);

endmodule
